// File: rtl/core/lph_pkg.sv
// Shared constants, codes and types for the linear-probe hash table.
package lph_pkg;

    // Table geometry: CAPACITY must be a power of two (home slot is the low hash bits)
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    // New keys are refused once count * 4 >= CAPACITY * 3
    localparam int LIMIT    = (CAPACITY * 3 + 3) / 4;
    localparam int CNT_W    = $clog2(LIMIT + 1);

    localparam int KEY_W  = 32;
    localparam int HASH_W = 32;
    localparam int VAL_W  = 64;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    // Write port of the slot store
    typedef struct packed {
        logic             key_we;
        logic             val_we;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_store_wr;

endpackage

// File: rtl/core/lph_if.sv
// Request and response channel interfaces of the hash table.
interface lph_req_if import lph_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic [VAL_W-1:0]  value;

    modport source (output valid, mode, key, hash, value, input ready);
    modport sink   (input valid, mode, key, hash, value, output ready);
endinterface

interface lph_rsp_if import lph_pkg::*; ();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [VAL_W-1:0] found_value;

    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface

// File: rtl/core/linear_probe_hash_table.sv
// Top level of the linear-probe hash table: probe sequencer and response register.
//
// Open-addressed hash map of CAPACITY slots (256) with linear probing. Each request
// transaction is an insert (mode 0) or a lookup (mode 1) of a nonzero key; the home
// slot is the low bits of the supplied hash and the probe walks forward with wrap.
// One request is handled at a time. After acceptance the sequencer checks each probed
// slot in S_CHECK, then on a lookup hit reads the value in S_VAL, and loads the result
// in S_RESP; a key of zero goes straight to S_RESP. The walk is paced by the single read
// port of the key memory, which is read once per probed slot. A finished response sits
// in an output register, so the next request is taken while it waits. Slots need no
// clearing pass: per-slot valid bits reset at once.
module linear_probe_hash_table_top import lph_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lph_req_if.sink   i_req,
    lph_rsp_if.source o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_VAL   = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state           r_state,  n_state;
    logic             r_mode,   n_mode;
    logic [KEY_W-1:0] r_key,    n_key;
    logic [VAL_W-1:0] r_value,  n_value;
    logic [IDX_W-1:0] r_idx,    n_idx;
    logic [IDX_W-1:0] r_n,      n_n;      // slots probed so far, less one
    logic [CNT_W-1:0] r_count,  n_count;  // occupied slots
    t_status          r_status, n_status;
    logic [VAL_W-1:0] r_found,  n_found;

    // response register
    logic             r_out_valid,  n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [VAL_W-1:0] r_out_found,  n_out_found;

    logic [IDX_W-1:0] key_rd_addr;
    logic [IDX_W-1:0] idx_inc;
    t_store_wr        wr;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic             out_free;
    logic             fail_status_lookup;

    lph_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_rd_addr(key_rd_addr),
        .i_val_rd_addr(r_idx),
        .i_wr         (wr),
        .o_rd_key     (rd_key),
        .o_rd_val     (rd_val)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_found;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign idx_inc  = (r_idx == IDX_W'(CAPACITY - 1)) ? '0 : r_idx + 1'b1;
    assign fail_status_lookup = (r_mode == MODE_LOOKUP);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_value      = r_value;
        n_idx        = r_idx;
        n_n          = r_n;
        n_count      = r_count;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        key_rd_addr  = r_idx;
        wr           = '0;
        wr.addr      = r_idx;
        wr.key       = r_key;
        wr.value     = r_value;

        // taken response frees the register
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // read of the home slot goes out with the accepting edge
                key_rd_addr = i_req.hash[IDX_W-1:0];
                if (i_req.valid) begin
                    n_mode   = i_req.mode;
                    n_key    = i_req.key;
                    n_value  = i_req.value;
                    n_idx    = i_req.hash[IDX_W-1:0];
                    n_n      = '0;
                    n_found  = '0;
                    n_status = ST_OK;
                    if (i_req.key == '0) begin
                        n_status = (i_req.mode == MODE_LOOKUP) ? ST_MISSING : ST_REFUSED;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (rd_key == r_key) begin
                    if (r_mode == MODE_LOOKUP) begin
                        n_state = S_VAL;       // value read in flight at r_idx
                    end else begin
                        wr.val_we = 1'b1;      // overwrite
                        n_state   = S_RESP;
                    end
                end else if (rd_key == '0) begin
                    if (r_mode == MODE_LOOKUP) begin
                        n_status = ST_MISSING;
                    end else if (r_count >= CNT_W'(LIMIT)) begin
                        n_status = ST_REFUSED;
                    end else begin
                        wr.key_we = 1'b1;
                        wr.val_we = 1'b1;
                        n_count   = r_count + 1'b1;
                    end
                    n_state = S_RESP;
                end else if (r_n == IDX_W'(CAPACITY - 1)) begin
                    // whole table walked without key or empty slot
                    n_status = fail_status_lookup ? ST_MISSING : ST_REFUSED;
                    n_state  = S_RESP;
                end else begin
                    n_idx       = idx_inc;
                    n_n         = r_n + 1'b1;
                    key_rd_addr = idx_inc;
                end
            end
            S_VAL: begin
                n_found = rd_val;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_value      <= n_value;
        r_idx        <= n_idx;
        r_n          <= n_n;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
    end

endmodule

// File: rtl/core/lph_store.sv
// Slot store: key memory with per-slot valid bits, and value memory.
module lph_store import lph_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_key_rd_addr,
    input  logic [IDX_W-1:0] i_val_rd_addr,
    input  t_store_wr        i_wr,
    output logic [KEY_W-1:0] o_rd_key,
    output logic [VAL_W-1:0] o_rd_val
);

    logic [KEY_W-1:0]    r_key_mem [CAPACITY];
    logic [VAL_W-1:0]    r_val_mem [CAPACITY];
    logic [CAPACITY-1:0] r_slot_vld;
    logic [KEY_W-1:0]    r_key_q;
    logic                r_vld_q;
    logic [VAL_W-1:0]    r_val_q;

    // valid bits: cleared at reset so every slot reads empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_vld_q    <= 1'b0;
        end else begin
            if (i_wr.key_we) begin
                r_slot_vld[i_wr.addr] <= 1'b1;
            end
            r_vld_q <= r_slot_vld[i_key_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key_mem[i_wr.addr] <= i_wr.key;
        end
        r_key_q <= r_key_mem[i_key_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.val_we) begin
            r_val_mem[i_wr.addr] <= i_wr.value;
        end
        r_val_q <= r_val_mem[i_val_rd_addr];
    end

    assign o_rd_key = r_vld_q ? r_key_q : '0;
    assign o_rd_val = r_val_q;

endmodule

// File: tb/sv/linear_probe_hash_table_top_tb.sv
// Self-checking testbench for the linear-probe hash table: directed, random and fill-to-limit traffic.
module linear_probe_hash_table_top_tb import lph_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted transaction before the run is declared hung.
    // A worst-case probe walks every slot of the table, and stalls or gaps
    // at 66 % come on top of that.
    localparam int WATCHDOG_LIMIT = 8 * CAPACITY + 2000;
    // Quiet cycles after the last response, to catch any stray response
    localparam int SETTLE_CYCLES  = 2 * CAPACITY;
    localparam int PHASE_ITEMS    = 110;
    // New keys offered beyond the load limit, all of which must be refused
    localparam int OVER_LIMIT     = 24;
    localparam int FULL_TAIL      = 30;

    typedef struct {
        t_status          status;
        logic [VAL_W-1:0] found_value;
    } t_answer;

    logic clk;
    logic rst_n;

    lph_req_if req_if ();
    lph_rsp_if rsp_if ();

    linear_probe_hash_table_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Shadow copy of the table, updated in acceptance order
    logic [KEY_W-1:0] shadow_keys   [CAPACITY];
    logic [VAL_W-1:0] shadow_values [CAPACITY];
    int               shadow_count;

    // Responses owed by the block, oldest first
    t_answer answer_q [$];

    // Keys offered for insertion by the random traffic, with the hash each one
    // always travels with (a key keeps a single hash, as real traffic would)
    logic [KEY_W-1:0]  key_pool  [$];
    logic [HASH_W-1:0] hash_pool [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int err_cnt       = 0;
    int quiet_cycles  = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response back-pressure: ready is redrawn every cycle at the current rate
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Works out the response to one request and applies its effect to the
    // shadow table. The probe starts at the home slot and walks forward with
    // wrap until it meets the key or an empty slot, visiting at most CAPACITY
    // slots. Key zero never probes: lookups miss and inserts are refused.
    function automatic t_answer resolve_request(
        input logic              mode,
        input logic [KEY_W-1:0]  key,
        input logic [HASH_W-1:0] hash,
        input logic [VAL_W-1:0]  value
    );
        t_answer     ans;
        int unsigned slot;
        int unsigned n;
        bit          stop;

        ans.status      = ST_OK;
        ans.found_value = '0;
        stop            = 1'b0;
        slot            = hash % CAPACITY;
        if (key != '0) begin
            for (n = 0; n < CAPACITY && !stop; n++) begin
                if (shadow_keys[slot] == '0 || shadow_keys[slot] == key) begin
                    stop = 1'b1;
                end else begin
                    slot = (slot + 1) % CAPACITY;
                end
            end
        end

        if (mode == MODE_LOOKUP) begin
            if (stop && shadow_keys[slot] == key) begin
                ans.found_value = shadow_values[slot];
            end else begin
                ans.status = ST_MISSING;
            end
        end else if (!stop) begin
            ans.status = ST_REFUSED;
        end else if (shadow_keys[slot] == key) begin
            // Overwrite is allowed even with the table at its limit
            shadow_values[slot] = value;
        end else if (shadow_count * 4 >= CAPACITY * 3) begin
            ans.status = ST_REFUSED;
        end else begin
            shadow_keys[slot]   = key;
            shadow_values[slot] = value;
            shadow_count++;
        end
        return ans;
    endfunction

    // Monitor on both channels. Signals are read straight after the edge, so
    // they still hold the values that the edge itself saw.
    always @(posedge clk) begin : monitor
        t_answer exp;
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                answer_q.push_back(resolve_request(req_if.mode, req_if.key,
                                                   req_if.hash, req_if.value));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected response: status %0d found_value %h",
                           rsp_if.status, rsp_if.found_value);
                    err_cnt++;
                end else begin
                    exp = answer_q.pop_front();
                    if (rsp_if.status !== exp.status) begin
                        $error("status mismatch: expected %0d actual %0d",
                               exp.status, rsp_if.status);
                        err_cnt++;
                    end
                    if (rsp_if.found_value !== exp.found_value) begin
                        $error("found_value mismatch: expected %h actual %h",
                               exp.found_value, rsp_if.found_value);
                        err_cnt++;
                    end
                end
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // One request transaction. A random gap may come first; valid is left high
    // on return so back-to-back transactions need no extra edge.
    task automatic send_req(
        input logic              mode,
        input logic [KEY_W-1:0]  key,
        input logic [HASH_W-1:0] hash,
        input logic [VAL_W-1:0]  value
    );
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.key   <= key;
        req_if.hash  <= hash;
        req_if.value <= value;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // Sender holds off until every owed response has come back
    task automatic wait_drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do k = $urandom(); while (k == '0);
        return k;
    endfunction

    // Half the hashes land in the slots around the wrap (the top eight and slots 0 to 7),
    // so chains pile up there and regularly wrap round to slot 0.
    function automatic logic [HASH_W-1:0] fresh_hash();
        logic [HASH_W-1:0] h;
        h = $urandom();
        if ($urandom_range(1) == 1) begin
            h[IDX_W-1:0] = IDX_W'(CAPACITY - 8 + $urandom_range(15));
        end
        return h;
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        return {$urandom(), $urandom()};
    endfunction

    task automatic insert_new_key();
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        key  = fresh_key();
        hash = fresh_hash();
        key_pool.push_back(key);
        hash_pool.push_back(hash);
        send_req(MODE_INSERT, key, hash, random_value());
    endtask

    // Insert (overwrite) or lookup of a key already offered, with its own hash
    task automatic reuse_key(input logic mode);
        int idx;
        idx = $urandom_range(key_pool.size() - 1);
        send_req(mode, key_pool[idx], hash_pool[idx], random_value());
    endtask

    // Key zero, empty table, chains across the wrap, overwrite, misses
    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        // key zero is never stored: lookup misses, insert is refused
        send_req(MODE_LOOKUP, '0, $urandom(), '0);
        send_req(MODE_INSERT, '0, 32'h0000_0005, '1);
        // empty table
        send_req(MODE_LOOKUP, 32'hFFFF_FFFF, '1, '0);
        // two keys homed on the last slot, the second wraps to slot 0;
        // a third homed on slot 0 gets pushed to slot 1
        send_req(MODE_INSERT, 32'h0000_0001, '1, '1);
        send_req(MODE_INSERT, 32'h0000_0002, '1, '0);
        send_req(MODE_INSERT, 32'hFFFF_FFFF, '0, 64'h5555_5555_5555_5555);
        send_req(MODE_LOOKUP, 32'h0000_0001, '1, '0);
        send_req(MODE_LOOKUP, 32'h0000_0002, '1, '1);
        send_req(MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        // same key found from an earlier home slot, walking through the wrap
        send_req(MODE_LOOKUP, 32'hFFFF_FFFF, '1, '0);
        // overwrite: value replaced, count unchanged
        send_req(MODE_INSERT, 32'h0000_0002, '1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_req(MODE_LOOKUP, 32'h0000_0002, '1, '0);
        // misses ending on the empty slot after the chain
        send_req(MODE_LOOKUP, 32'h0000_0003, '1, '0);
        send_req(MODE_LOOKUP, 32'h8000_0000, 32'h8000_0000, '0);
        // key zero against an occupied home slot
        send_req(MODE_LOOKUP, '0, '1, '0);
        send_req(MODE_INSERT, '0, '0, '0);
        wait_drain();
    endtask

    // Mostly well-formed traffic on a growing set of keys, with some noise:
    // unknown keys, known keys under a wrong hash and key zero.
    task automatic test_random_phase(input int src_pct, input int snk_pct, input int n_items);
        int i;
        int pick;
        int idx;

        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (pick < 30 || key_pool.size() == 0) begin
                insert_new_key();
            end else if (pick < 60) begin
                reuse_key(MODE_LOOKUP);
            end else if (pick < 78) begin
                reuse_key(MODE_INSERT);
            end else if (pick < 88) begin
                send_req(MODE_LOOKUP, fresh_key(), fresh_hash(), random_value());
            end else if (pick < 95) begin
                idx = $urandom_range(key_pool.size() - 1);
                send_req(MODE_LOOKUP, key_pool[idx], fresh_hash(), random_value());
            end else begin
                send_req(logic'($urandom_range(1)), '0, $urandom(), random_value());
            end
        end
        wait_drain();
    endtask

    // Drives the count up to three quarters of capacity and offers new keys past it:
    // those are refused there, while overwrites and lookups still go through.
    task automatic test_table_full();
        int i;
        int pick;

        src_idle_pct  = 38;
        snk_stall_pct = 38;
        while (key_pool.size() < LIMIT + OVER_LIMIT) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                insert_new_key();
            end else if (pick < 75) begin
                reuse_key(MODE_INSERT);
            end else begin
                reuse_key(MODE_LOOKUP);
            end
        end
        for (i = 0; i < FULL_TAIL; i++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                insert_new_key();
            end else if (pick < 60) begin
                reuse_key(MODE_INSERT);
            end else begin
                reuse_key(MODE_LOOKUP);
            end
        end
        wait_drain();
    endtask

    initial begin
        for (int s = 0; s < CAPACITY; s++) begin
            shadow_keys[s]   = '0;
            shadow_values[s] = '0;
        end
        shadow_count  = 0;
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.mode   = MODE_INSERT;
        req_if.key    = '0;
        req_if.hash   = '0;
        req_if.value  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phase(0, 0, PHASE_ITEMS);
        test_random_phase(66, 0, PHASE_ITEMS);
        test_random_phase(0, 66, PHASE_ITEMS);
        test_random_phase(38, 38, PHASE_ITEMS);
        // pressure point: the sender has already paused until all responses
        // came back; the fill runs from an idle block
        test_table_full();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/lph_pkg.sv
rtl/core/lph_if.sv
rtl/core/lph_store.sv
rtl/core/linear_probe_hash_table.sv
tb/sv/linear_probe_hash_table_top_tb.sv
